// File: src/rdv_pkg.sv
package rdv_pkg;

    localparam int CHANGE_W   = 25;
    localparam int VOL_W      = 28;
    localparam int NW         = 7;
    localparam int DEN_W      = 2 * NW;
    localparam int VAR_SHIFT  = 2 * (CHANGE_W - 1);
    localparam int SCALE_BITS = 8;
    localparam int QUO_W      = VAR_SHIFT + SCALE_BITS;
    localparam int ROOT_W     = QUO_W / 2;
    localparam int OUT_DATA_W = ((CHANGE_W + VOL_W + 7) / 8) * 8;

    localparam int DEFAULT_WINDOW = 30;
    localparam int MIN_WINDOW     = 2;

    // register select, paddr[2]
    localparam logic REG_WINDOW_LENGTH = 1'b0;

endpackage

// File: src/rdv_ram.sv
module rdv_ram
#(
    parameter int WIDTH = 25,
    parameter int DEPTH = 64
)
(
    input  logic                            clk,
    input  logic                            we,
    input  logic [$clog2(DEPTH)-1:0]        waddr,
    input  logic [WIDTH-1:0]                wdata,
    input  logic [$clog2(DEPTH)-1:0]        raddr,
    output logic [WIDTH-1:0]                rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/rdv_smul.sv
module rdv_smul
#(
    parameter int A_W = 25,
    parameter int B_W = 25
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic                 busy,
    output logic [A_W+B_W-1:0]   p
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]     a_reg;
    logic [A_W+B_W-1:0] p_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic [A_W:0]       acc_next;

    // shift-add, one multiplier bit per cycle
    assign acc_next = {1'b0, p_reg[A_W+B_W-1:B_W]} + (p_reg[0] ? {1'b0, a_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(B_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            p_reg <= {{A_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            p_reg <= {acc_next, p_reg[B_W-1:1]};
        end
    end

    assign busy = busy_reg;
    assign p    = p_reg;

endmodule

// File: src/rdv_div.sv
module rdv_div
    import rdv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DEN_W-1:0]   high,
    input  logic [QUO_W-1:0]   low,
    input  logic [DEN_W-1:0]   den,
    output logic               busy,
    output logic [QUO_W-1:0]   quo
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [QUO_W-1:0] q_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;

    // restoring division; high part is below den so the quotient fits QUO_W
    assign trial = {rem_reg, q_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign take  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QUO_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= high;
            q_reg   <= low;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_reg   <= {q_reg[QUO_W-2:0], take};
        end
    end

    assign busy = busy_reg;
    assign quo  = q_reg;

endmodule

// File: src/rdv_sqrt.sv
module rdv_sqrt
    import rdv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [QUO_W-1:0]    value,
    output logic                busy,
    output logic [ROOT_W-1:0]   root
);

    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [QUO_W-1:0]  v_reg;
    logic [ROOT_W:0]   rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [ROOT_W+2:0] rem_sh;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] diff;
    logic              take;

    // two radicand bits per cycle
    assign rem_sh = {rem_reg, v_reg[QUO_W-1:QUO_W-2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign diff   = rem_sh - trial;
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg    <= {v_reg[QUO_W-3:0], 2'b00};
            rem_reg  <= take ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// File: src/rolling_difference_volatility_top.sv
// Sliding-window volatility of price changes. Each request on the slave side carries one
// price; the block returns one request per price with the change from the previous price,
// and, once window_length changes are held, the population standard deviation of the window
// in ticks with 4 fraction bits (volatility_valid in m_tuser). One price is worked on at a
// time. The first price after reset or a config write only sets the previous price; for
// every later one the bit-serial units run: the squares of the new and the dropped change
// and of the window sum, then, once the window is full, the multiply by N, the restoring
// divide by N*N and the square root, in turn. The result sits in an output register, so
// the next price is taken while it waits. A write to window_length (its low 7 bits clamp to
// 2..MAX_WINDOW, at most 127) clears the window and the previous price; write it only while
// idle.
module rolling_difference_volatility_top
    import rdv_pkg::*;
#(
    parameter  int MAX_WINDOW = 64,
    parameter  int PRICE_BITS = 24,
    localparam int S_DATA_W   = ((PRICE_BITS + 7) / 8) * 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,

    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_DATA_W-1:0]     s_tdata,    // price

    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata,    // price_change, volatility
    output logic                    m_tuser     // volatility_valid
);

    localparam int NMAX  = (MAX_WINDOW > 127) ? 127 : MAX_WINDOW;
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW    = (AW + 1 > NW) ? AW + 1 : NW;
    localparam int LOG_N = $clog2(NMAX);
    localparam int SUM_W = CHANGE_W + LOG_N;
    localparam int SQ_W  = 2 * CHANGE_W - 1 + LOG_N;
    localparam int A_W   = SQ_W + NW;
    localparam int B_W   = 2 * SUM_W;
    localparam int NUM_W = (A_W > B_W) ? A_W : B_W;
    localparam int DW    = (PRICE_BITS + 1 > CHANGE_W) ? PRICE_BITS + 1 : CHANGE_W;
    localparam int RST_N = (DEFAULT_WINDOW > NMAX) ? NMAX : DEFAULT_WINDOW;

    localparam logic [NW-1:0]        NMAX_N  = NW'(NMAX);
    localparam logic [NW-1:0]        NMIN_N  = NW'(MIN_WINDOW);
    localparam logic signed [DW-1:0] CH_HI   = DW'(2 ** (CHANGE_W - 1) - 1);
    localparam logic signed [DW-1:0] CH_LO   = ~CH_HI;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SUMSQ,
        ST_MUL,
        ST_SCALE,
        ST_NMUL,
        ST_DIV,
        ST_ROOT,
        ST_DONE
    } state_t;

    state_t                     state_reg;
    logic [NW-1:0]              wl_reg;
    logic [PRICE_BITS-1:0]      prev_reg;
    logic                       have_prev_reg;
    logic [AW-1:0]              pos_reg;
    logic [NW-1:0]              filled_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]            sumsq_reg;
    logic signed [CHANGE_W-1:0] change_reg;
    logic                       full_reg;

    logic                       mt_valid_reg;
    logic [CHANGE_W-1:0]        out_change_reg;
    logic [VOL_W-1:0]           out_vol_reg;
    logic                       out_vv_reg;

    logic                       accept;
    logic                       cfg_we;
    logic                       out_load;
    logic [NW-1:0]              wl_next;
    logic [PRICE_BITS-1:0]      price;
    logic signed [DW-1:0]       diff;
    logic signed [CHANGE_W-1:0] change_next;
    logic [CHANGE_W-1:0]        ram_rdata;
    logic                       full_before;
    logic signed [CHANGE_W-1:0] old_val;
    logic [CHANGE_W-1:0]        abs_c;
    logic [CHANGE_W-1:0]        abs_old;
    logic [SUM_W-1:0]           abs_sum;
    logic signed [SUM_W-1:0]    sum_next;
    logic [SQ_W-1:0]            sumsq_next;
    logic [CW-1:0]              pos_inc;
    logic [AW-1:0]              pos_next;
    logic [NW-1:0]              filled_inc;
    logic [DEN_W-1:0]           nn;
    logic [NUM_W-1:0]           a_ext;
    logic [NUM_W-1:0]           b_ext;
    logic [NUM_W-1:0]           num;
    logic [NUM_W-1:0]           num_high;

    logic                       sq_start;
    logic                       ssq_start;
    logic                       nmul_start;
    logic                       div_start;
    logic                       root_start;
    logic                       sq_busy;
    logic                       osq_busy;
    logic                       ssq_busy;
    logic                       nmul_busy;
    logic                       div_busy;
    logic                       root_busy;
    logic [2*CHANGE_W-1:0]      sq_p;
    logic [2*CHANGE_W-1:0]      osq_p;
    logic [B_W-1:0]             ssq_p;
    logic [A_W-1:0]             nmul_p;
    logic [QUO_W-1:0]           quo;
    logic [ROOT_W-1:0]          root;

    // config port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);
    assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ? 32'(wl_reg) : '0;

    always_comb
    begin
        wl_next = pwdata[NW-1:0];
        if (wl_next < NMIN_N)
        begin
            wl_next = NMIN_N;
        end
        else if (wl_next > NMAX_N)
        begin
            wl_next = NMAX_N;
        end
    end

    // price change, saturated
    assign accept = s_tvalid && s_tready;
    assign price  = s_tdata[PRICE_BITS-1:0];
    assign diff   = $signed(DW'(price)) - $signed(DW'(prev_reg));

    always_comb
    begin
        if (diff > CH_HI)
        begin
            change_next = CH_HI[CHANGE_W-1:0];
        end
        else if (diff < CH_LO)
        begin
            change_next = CH_LO[CHANGE_W-1:0];
        end
        else
        begin
            change_next = diff[CHANGE_W-1:0];
        end
    end

    rdv_ram #(
        .WIDTH (CHANGE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (accept && have_prev_reg),
        .waddr (pos_reg),
        .wdata (change_next),
        .raddr (pos_reg),
        .rdata (ram_rdata)
    );

    // window update
    assign full_before = (filled_reg >= wl_reg);
    assign old_val     = full_before ? $signed(ram_rdata) : '0;
    assign abs_c       = change_reg[CHANGE_W-1] ? $unsigned(-change_reg) : $unsigned(change_reg);
    assign abs_old     = old_val[CHANGE_W-1] ? $unsigned(-old_val) : $unsigned(old_val);
    assign abs_sum     = sum_reg[SUM_W-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);
    assign sum_next    = sum_reg + SUM_W'(change_reg) - SUM_W'(old_val);
    assign sumsq_next  = sumsq_reg + SQ_W'(sq_p) - SQ_W'(osq_p);
    assign pos_inc     = CW'(pos_reg) + 1'b1;
    assign pos_next    = (pos_inc >= CW'(wl_reg)) ? '0 : pos_inc[AW-1:0];
    assign filled_inc  = filled_reg + 1'b1;

    // variance numerator N*sumsq - sum^2, scaled by 256 in the divider
    assign nn       = DEN_W'(wl_reg) * DEN_W'(wl_reg);
    assign a_ext    = NUM_W'(nmul_p);
    assign b_ext    = NUM_W'(ssq_p);
    assign num      = (a_ext > b_ext) ? a_ext - b_ext : '0;
    assign num_high = num >> VAR_SHIFT;

    assign sq_start   = (state_reg == ST_READ);
    assign ssq_start  = (state_reg == ST_SUMSQ);
    assign nmul_start = (state_reg == ST_SCALE);
    assign div_start  = (state_reg == ST_NMUL) && !nmul_busy;
    assign root_start = (state_reg == ST_DIV) && !div_busy;

    rdv_smul #(.A_W (CHANGE_W), .B_W (CHANGE_W)) u_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .a     (abs_c),
        .b     (abs_c),
        .busy  (sq_busy),
        .p     (sq_p)
    );

    rdv_smul #(.A_W (CHANGE_W), .B_W (CHANGE_W)) u_osq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .a     (abs_old),
        .b     (abs_old),
        .busy  (osq_busy),
        .p     (osq_p)
    );

    rdv_smul #(.A_W (SUM_W), .B_W (SUM_W)) u_ssq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ssq_start),
        .a     (abs_sum),
        .b     (abs_sum),
        .busy  (ssq_busy),
        .p     (ssq_p)
    );

    rdv_smul #(.A_W (SQ_W), .B_W (NW)) u_nmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (nmul_start),
        .a     (sumsq_reg),
        .b     (wl_reg),
        .busy  (nmul_busy),
        .p     (nmul_p)
    );

    rdv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .high  (DEN_W'(num_high)),
        .low   ({num[VAR_SHIFT-1:0], SCALE_BITS'(0)}),
        .den   (nn),
        .busy  (div_busy),
        .quo   (quo)
    );

    rdv_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .value (quo),
        .busy  (root_busy),
        .root  (root)
    );

    assign out_load = (state_reg == ST_DONE) && !cfg_we && (!mt_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wl_reg         <= NW'(RST_N);
            prev_reg       <= '0;
            have_prev_reg  <= 1'b0;
            pos_reg        <= '0;
            filled_reg     <= '0;
            sum_reg        <= '0;
            sumsq_reg      <= '0;
            change_reg     <= '0;
            full_reg       <= 1'b0;
            mt_valid_reg   <= 1'b0;
            out_change_reg <= '0;
            out_vol_reg    <= '0;
            out_vv_reg     <= 1'b0;
        end
        else
        begin
            if (mt_valid_reg && m_tready && !out_load)
            begin
                mt_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                wl_reg        <= wl_next;
                prev_reg      <= '0;
                have_prev_reg <= 1'b0;
                pos_reg       <= '0;
                filled_reg    <= '0;
                sum_reg       <= '0;
                sumsq_reg     <= '0;
            end
            else
            begin
                case (state_reg)
                    ST_IDLE:
                    begin
                        if (accept)
                        begin
                            prev_reg      <= price;
                            have_prev_reg <= 1'b1;
                            change_reg    <= have_prev_reg ? change_next : '0;
                            full_reg      <= 1'b0;
                            state_reg     <= have_prev_reg ? ST_READ : ST_DONE;
                        end
                    end
                    ST_READ:
                    begin
                        sum_reg  <= sum_next;
                        pos_reg  <= pos_next;
                        full_reg <= full_before || (filled_inc >= wl_reg);
                        if (!full_before)
                        begin
                            filled_reg <= filled_inc;
                        end
                        state_reg <= ST_SUMSQ;
                    end
                    ST_SUMSQ:
                    begin
                        state_reg <= ST_MUL;
                    end
                    ST_MUL:
                    begin
                        if (!sq_busy && !osq_busy && !ssq_busy)
                        begin
                            sumsq_reg <= sumsq_next;
                            state_reg <= full_reg ? ST_SCALE : ST_DONE;
                        end
                    end
                    ST_SCALE:
                    begin
                        state_reg <= ST_NMUL;
                    end
                    ST_NMUL:
                    begin
                        if (!nmul_busy)
                        begin
                            state_reg <= ST_DIV;
                        end
                    end
                    ST_DIV:
                    begin
                        if (!div_busy)
                        begin
                            state_reg <= ST_ROOT;
                        end
                    end
                    ST_ROOT:
                    begin
                        if (!root_busy)
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                    ST_DONE:
                    begin
                        if (out_load)
                        begin
                            mt_valid_reg   <= 1'b1;
                            out_change_reg <= change_reg;
                            out_vol_reg    <= full_reg ? VOL_W'(root) : '0;
                            out_vv_reg     <= full_reg;
                            state_reg      <= ST_IDLE;
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE) && !cfg_we;
    assign m_tvalid = mt_valid_reg;
    assign m_tdata  = OUT_DATA_W'({out_vol_reg, out_change_reg});
    assign m_tuser  = out_vv_reg;

    a_idle_units: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(sq_busy || osq_busy || ssq_busy || nmul_busy || div_busy || root_busy))
        else $error("request taken while an arithmetic unit is busy");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(pos_reg) < CW'(wl_reg))
        else $error("ring position beyond window length");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= wl_reg)
        else $error("fill count beyond window length");

    a_full_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && full_reg) |-> (filled_reg == wl_reg))
        else $error("volatility reported on a window that is not full");

endmodule
